>>> rtl/core/cpsc_pkg.sv
// shared types and constants of the cascaded pi shift controller
package cpsc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int GAIN_W     = 31;
    localparam int SHIFT_W    = 15;

    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    localparam logic [GAIN_W-1:0]  KP_VOLTAGE_RST = 31'd2300314;
    localparam logic [GAIN_W-1:0]  KI_VOLTAGE_RST = 31'd268698;
    localparam logic [GAIN_W-1:0]  KA_VOLTAGE_RST = 31'd1867;
    localparam logic [GAIN_W-1:0]  KP_CURRENT_RST = 31'd6554;
    localparam logic [GAIN_W-1:0]  KI_CURRENT_RST = 31'd598;
    localparam logic [GAIN_W-1:0]  KA_CURRENT_RST = 31'd655360;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX_RST  = 15'd32767;
    localparam logic [SHIFT_W-1:0] SHIFT_MIN_RST  = 15'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_VOLTAGE = 3'd0,
        REG_KI_VOLTAGE = 3'd1,
        REG_KA_VOLTAGE = 3'd2,
        REG_KP_CURRENT = 3'd3,
        REG_KI_CURRENT = 3'd4,
        REG_KA_CURRENT = 3'd5,
        REG_SHIFT_MAX  = 3'd6,
        REG_SHIFT_MIN  = 3'd7
    } cpsc_reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp_voltage;
        logic [GAIN_W-1:0]  ki_voltage;
        logic [GAIN_W-1:0]  ka_voltage;
        logic [GAIN_W-1:0]  kp_current;
        logic [GAIN_W-1:0]  ki_current;
        logic [GAIN_W-1:0]  ka_current;
        logic [SHIFT_W-1:0] shift_max;
        logic [SHIFT_W-1:0] shift_min;
    } cpsc_cfg_t;

    typedef struct packed {
        logic signed [31:0] voltage_reference;
        logic signed [31:0] current_limit;
        logic signed [31:0] voltage_feedback;
        logic signed [31:0] current_feedback;
    } cpsc_in_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift_value;
    } cpsc_out_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } cpsc_alu_op_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_EV,
        DST_T,
        DST_IV,
        DST_RV,
        DST_CV,
        DST_WV,
        DST_EI,
        DST_IC,
        DST_RI,
        DST_CI,
        DST_WI
    } cpsc_dst_t;

    typedef enum logic [1:0] {
        CI_PASS,
        CI_UPPER,
        CI_LOWER
    } cpsc_ci_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EV,
        ST_EVW,
        ST_MKIV,
        ST_IV,
        ST_PV,
        ST_RV,
        ST_CV,
        ST_DV,
        ST_WV,
        ST_EI,
        ST_EIW,
        ST_MKIC,
        ST_IC,
        ST_PC,
        ST_RI,
        ST_CI,
        ST_DI,
        ST_WI
    } cpsc_state_t;

endpackage

>>> rtl/core/cpsc_stream_if.sv
// valid/ready stream channel carrying one word of type T
interface cpsc_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/cpsc_cfg_regs.sv
// configuration register file of the cascaded pi shift controller
module cpsc_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cpsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpsc_pkg::CFG_DATA_W-1:0] cfg_data,
    output cpsc_pkg::cpsc_cfg_t             cfg
);
    import cpsc_pkg::*;

    cpsc_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_voltage <= KP_VOLTAGE_RST;
            cfg_reg.ki_voltage <= KI_VOLTAGE_RST;
            cfg_reg.ka_voltage <= KA_VOLTAGE_RST;
            cfg_reg.kp_current <= KP_CURRENT_RST;
            cfg_reg.ki_current <= KI_CURRENT_RST;
            cfg_reg.ka_current <= KA_CURRENT_RST;
            cfg_reg.shift_max  <= SHIFT_MAX_RST;
            cfg_reg.shift_min  <= SHIFT_MIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cpsc_reg_idx_t'(cfg_index))
                REG_KP_VOLTAGE: cfg_reg.kp_voltage <= cfg_data;
                REG_KI_VOLTAGE: cfg_reg.ki_voltage <= cfg_data;
                REG_KA_VOLTAGE: cfg_reg.ka_voltage <= cfg_data;
                REG_KP_CURRENT: cfg_reg.kp_current <= cfg_data;
                REG_KI_CURRENT: cfg_reg.ki_current <= cfg_data;
                REG_KA_CURRENT: cfg_reg.ka_current <= cfg_data;
                REG_SHIFT_MAX:  cfg_reg.shift_max  <= cfg_data[SHIFT_W-1:0];
                REG_SHIFT_MIN:  cfg_reg.shift_min  <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/cpsc_alu.sv
// shared saturating add/subtract and gain multiply unit
module cpsc_alu #(
    parameter int FRAC_BITS = 16,
    parameter int AW        = 34
) (
    input  cpsc_pkg::cpsc_alu_op_t          op,
    input  logic signed [AW-1:0]            a,
    input  logic signed [AW-1:0]            b,
    input  logic [cpsc_pkg::GAIN_W-1:0]     g,
    output logic signed [31:0]              y
);
    import cpsc_pkg::*;

    localparam logic signed [AW:0] SUM_MAX = (AW+1)'(S32_MAX);
    localparam logic signed [AW:0] SUM_MIN = (AW+1)'(S32_MIN);
    localparam logic signed [63:0] PRD_MAX = 64'(S32_MAX);
    localparam logic signed [63:0] PRD_MIN = 64'(S32_MIN);

    logic signed [AW:0] sum;
    logic signed [63:0] prod;
    logic signed [63:0] quo;

    always_comb
    begin
        sum  = (op == ALU_SUB) ? ((AW+1)'(a) - (AW+1)'(b)) : ((AW+1)'(a) + (AW+1)'(b));
        // floor shift of the exact product
        prod = 64'($signed(a[31:0])) * 64'($signed({1'b0, g}));
        quo  = prod >>> FRAC_BITS;
        unique case (op)
            ALU_MUL:
            begin
                if (quo > PRD_MAX)
                    y = S32_MAX;
                else if (quo < PRD_MIN)
                    y = S32_MIN;
                else
                    y = $signed(quo[31:0]);
            end
            default:
            begin
                if (sum > SUM_MAX)
                    y = S32_MAX;
                else if (sum < SUM_MIN)
                    y = S32_MIN;
                else
                    y = $signed(sum[31:0]);
            end
        endcase
    end

endmodule

>>> rtl/core/cascaded_pi_shift_controller_core.sv
// top level of the cascaded pi shift controller: sequencer and datapath registers
// The sample word is taken in the idle state; after acceptance the sequencer
// runs 18 steps, 16 of which each run one saturating add, subtract or gain
// multiply on the single shared arithmetic unit and two of which clamp a loop
// output (outer voltage loop, then inner current loop). The result word sits
// in an output register, so a new sample is taken while the previous result
// is still waiting; the last step holds only if that register is still full.
// Configuration writes take effect at once and should be made while no
// sample is in progress.
module cascaded_pi_shift_controller_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cpsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpsc_pkg::CFG_DATA_W-1:0] cfg_data,
    cpsc_stream_if.sink                     in_ch,
    cpsc_stream_if.source                   out_ch
);
    import cpsc_pkg::*;

    localparam int LIM_W = SHIFT_W + FRAC_BITS + 1;
    localparam int AW    = ((LIM_W > 33) ? LIM_W : 33) + 1;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    cpsc_cfg_t cfg;

    cpsc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cpsc_state_t state_reg, state_next;

    // loop state
    logic signed [31:0] iv_reg, wv_reg, ic_reg, wi_reg;
    // sample and intermediates
    logic signed [31:0] vref_reg, ilim_reg, vfb_reg, ifb_reg;
    logic signed [31:0] ev_reg, ei_reg, t_reg, rv_reg, cv_reg, ri_reg;
    cpsc_ci_sel_t       ci_sel_reg;
    logic [SHIFT_W-1:0] shv_reg;
    logic               out_valid_reg;
    cpsc_out_t          out_data_reg;

    cpsc_alu_op_t       alu_op;
    logic signed [AW-1:0] alu_a, alu_b;
    logic [GAIN_W-1:0]  alu_g;
    logic signed [31:0] alu_y;
    cpsc_dst_t          dst;

    logic               slot_free;
    logic               in_acc;
    logic signed [AW-1:0] upper_w, lower_w, ri_w, ci_w;
    logic signed [31:0] cv_next;
    cpsc_ci_sel_t       ci_sel_next;
    logic [SHIFT_W-1:0] shv_next;

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_data_reg;

    cpsc_alu #(
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .g  (alu_g),
        .y  (alu_y)
    );

    // clamps
    assign upper_w = AW'($signed({1'b0, cfg.shift_max, {FRAC_BITS{1'b0}}}));
    assign lower_w = AW'($signed({1'b0, cfg.shift_min, {FRAC_BITS{1'b0}}}));
    assign ri_w    = AW'(ri_reg);

    always_comb
    begin
        // upper bound is checked first
        if (rv_reg >= ilim_reg)
            cv_next = ilim_reg;
        else if (rv_reg <= ONE)
            cv_next = ONE;
        else
            cv_next = rv_reg;

        if (ri_w >= upper_w)
        begin
            ci_sel_next = CI_UPPER;
            shv_next    = cfg.shift_max;
        end
        else if (ri_w <= lower_w)
        begin
            ci_sel_next = CI_LOWER;
            shv_next    = cfg.shift_min;
        end
        else
        begin
            ci_sel_next = CI_PASS;
            shv_next    = SHIFT_W'(ri_reg >>> FRAC_BITS);
        end

        case (ci_sel_reg)
            CI_UPPER: ci_w = upper_w;
            CI_LOWER: ci_w = lower_w;
            default:  ci_w = ri_w;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc) state_next = ST_EV;
            ST_EV:   state_next = ST_EVW;
            ST_EVW:  state_next = ST_MKIV;
            ST_MKIV: state_next = ST_IV;
            ST_IV:   state_next = ST_PV;
            ST_PV:   state_next = ST_RV;
            ST_RV:   state_next = ST_CV;
            ST_CV:   state_next = ST_DV;
            ST_DV:   state_next = ST_WV;
            ST_WV:   state_next = ST_EI;
            ST_EI:   state_next = ST_EIW;
            ST_EIW:  state_next = ST_MKIC;
            ST_MKIC: state_next = ST_IC;
            ST_IC:   state_next = ST_PC;
            ST_PC:   state_next = ST_RI;
            ST_RI:   state_next = ST_CI;
            ST_CI:   state_next = ST_DI;
            ST_DI:   state_next = ST_WI;
            ST_WI:   if (slot_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // step decode: operands of the shared unit and the register written
    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        alu_g  = '0;
        dst    = DST_NONE;
        unique case (state_reg)
            ST_EV:
            begin
                alu_op = ALU_SUB; alu_a = AW'(vref_reg); alu_b = AW'(vfb_reg); dst = DST_EV;
            end
            ST_EVW:
            begin
                alu_op = ALU_SUB; alu_a = AW'(ev_reg); alu_b = AW'(wv_reg); dst = DST_T;
            end
            ST_MKIV:
            begin
                alu_op = ALU_MUL; alu_a = AW'(t_reg); alu_g = cfg.ki_voltage; dst = DST_T;
            end
            ST_IV:
            begin
                alu_a = AW'(iv_reg); alu_b = AW'(t_reg); dst = DST_IV;
            end
            ST_PV:
            begin
                alu_op = ALU_MUL; alu_a = AW'(ev_reg); alu_g = cfg.kp_voltage; dst = DST_T;
            end
            ST_RV:
            begin
                alu_a = AW'(t_reg); alu_b = AW'(iv_reg); dst = DST_RV;
            end
            ST_CV:   dst = DST_CV;
            ST_DV:
            begin
                alu_op = ALU_SUB; alu_a = AW'(rv_reg); alu_b = AW'(cv_reg); dst = DST_T;
            end
            ST_WV:
            begin
                alu_op = ALU_MUL; alu_a = AW'(t_reg); alu_g = cfg.ka_voltage; dst = DST_WV;
            end
            ST_EI:
            begin
                alu_op = ALU_SUB; alu_a = AW'(cv_reg); alu_b = AW'(ifb_reg); dst = DST_EI;
            end
            ST_EIW:
            begin
                alu_op = ALU_SUB; alu_a = AW'(ei_reg); alu_b = AW'(wi_reg); dst = DST_T;
            end
            ST_MKIC:
            begin
                alu_op = ALU_MUL; alu_a = AW'(t_reg); alu_g = cfg.ki_current; dst = DST_T;
            end
            ST_IC:
            begin
                alu_a = AW'(ic_reg); alu_b = AW'(t_reg); dst = DST_IC;
            end
            ST_PC:
            begin
                alu_op = ALU_MUL; alu_a = AW'(ei_reg); alu_g = cfg.kp_current; dst = DST_T;
            end
            ST_RI:
            begin
                alu_a = AW'(t_reg); alu_b = AW'(ic_reg); dst = DST_RI;
            end
            ST_CI:   dst = DST_CI;
            ST_DI:
            begin
                // shift limits may exceed 32 bits, so the wide clamp value is used
                alu_op = ALU_SUB; alu_a = ri_w; alu_b = ci_w; dst = DST_T;
            end
            ST_WI:
            begin
                alu_op = ALU_MUL; alu_a = AW'(t_reg); alu_g = cfg.ka_current;
                if (slot_free) dst = DST_WI;
            end
            default: dst = DST_NONE;
        endcase
    end

    // control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iv_reg        <= '0;
            wv_reg        <= '0;
            ic_reg        <= '0;
            wi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (dst == DST_IV) iv_reg <= alu_y;
            if (dst == DST_WV) wv_reg <= alu_y;
            if (dst == DST_IC) ic_reg <= alu_y;
            if (dst == DST_WI) wi_reg <= alu_y;
            if (dst == DST_WI)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // sample and intermediate registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            vref_reg <= in_ch.data.voltage_reference;
            ilim_reg <= in_ch.data.current_limit;
            vfb_reg  <= in_ch.data.voltage_feedback;
            ifb_reg  <= in_ch.data.current_feedback;
        end
        case (dst)
            DST_EV: ev_reg <= alu_y;
            DST_T:  t_reg  <= alu_y;
            DST_RV: rv_reg <= alu_y;
            DST_CV: cv_reg <= cv_next;
            DST_EI: ei_reg <= alu_y;
            DST_RI: ri_reg <= alu_y;
            DST_CI:
            begin
                ci_sel_reg <= ci_sel_next;
                shv_reg    <= shv_next;
            end
            DST_WI: out_data_reg.shift_value <= shv_reg;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == ST_EV)
        else $error("accepted sample did not start the sequence");

    a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WI && slot_free) |=> out_ch.valid && state_reg == ST_IDLE)
        else $error("finished sample did not post a result word");

    a_cv_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CV |=> (cv_reg == ilim_reg) || (cv_reg >= ONE))
        else $error("outer loop output outside its clamp");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready && state_reg == ST_WI) |=> state_reg == ST_WI)
        else $error("sequence left the last step while the result word was full");
`endif

endmodule
